[hw/rtl/mdp_pkg.sv]
package mdp_pkg;

    // Fixed-point format of z and c
    localparam int FRACTION_BITS = 28;
    localparam int CPW           = 32;               // width of a point coordinate
    localparam int ZW            = FRACTION_BITS + 3; // signed z while |z| < 4
    localparam int PW            = 2 * ZW;            // signed product width
    localparam int MW            = PW + 1;            // |z|^2 sum width
    localparam int NW            = ((ZW > CPW) ? ZW : CPW) + 2; // z right after update

    // Iteration limit register
    localparam int                CW          = 11;
    localparam logic [CW-1:0]     LIMIT_MAX   = 11'd1024;
    localparam logic [CW-1:0]     LIMIT_RESET = 11'd64;

    // Escape bound 4.0 on |z|^2, and bound 4.0 on a single coordinate
    localparam logic [MW-1:0]        FOUR_SQ = {{(MW-1){1'b0}}, 1'b1} << (2 * FRACTION_BITS + 2);
    localparam logic signed [NW-1:0] Z_LIM   = {{(NW-1){1'b0}}, 1'b1} << (FRACTION_BITS + 2);

    // Square root of |z|^2 scaled by 2^30
    localparam int ROOT_SHIFT = 2 * FRACTION_BITS - 30;
    localparam int RW         = 34;                  // radicand width, even
    localparam int QW         = RW / 2;              // root width
    localparam int DW         = 17;                  // density width
    localparam logic [DW-1:0] ONE_DENSITY = 17'h10000;

    typedef struct packed {
        logic busy;
        logic done;
    } t_sqrt_stat;

    // A coordinate this large escapes no matter what the other one is
    function automatic logic f_far(input logic signed [NW-1:0] v);
        return (v >= Z_LIM) || (v <= -Z_LIM);
    endfunction

    // Zero counts as one, anything above the maximum saturates
    function automatic logic [CW-1:0] f_eff_limit(input logic [CW-1:0] v);
        logic [CW-1:0] r;
        if (v == '0) begin
            r = {{(CW-1){1'b0}}, 1'b1};
        end else if (v > LIMIT_MAX) begin
            r = LIMIT_MAX;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

[hw/rtl/mdp_mul.sv]
module mdp_mul (
    input  logic                           i_clk,
    input  logic signed [mdp_pkg::ZW-1:0]  i_a,
    input  logic signed [mdp_pkg::ZW-1:0]  i_b,
    output logic signed [mdp_pkg::PW-1:0]  o_prod
);

    logic signed [mdp_pkg::PW-1:0] r_prod;

    // Shared signed multiplier, one registered product per cycle
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

[hw/rtl/mdp_isqrt.sv]
module mdp_isqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [mdp_pkg::RW-1:0]      i_radicand,
    output logic [mdp_pkg::QW-1:0]      o_root,
    output mdp_pkg::t_sqrt_stat         o_stat
);

    localparam int QW  = mdp_pkg::QW;
    localparam int RW  = mdp_pkg::RW;
    localparam int SCW = $clog2(QW);

    logic            r_busy;
    logic            r_done;
    logic [SCW-1:0]  r_cnt;
    logic [RW-1:0]   r_rad;
    logic [QW:0]     r_rem;
    logic [QW-1:0]   r_root;

    logic [QW+2:0]   rem_sh;
    logic [QW+2:0]   trial;
    logic [QW+2:0]   diff;
    logic            take;

    // One result bit per cycle: bring down two radicand bits, try 4*root+1
    always_comb begin
        rem_sh = {r_rem, r_rad[RW-1 -: 2]};
        trial  = {1'b0, r_root, 2'b01};
        diff   = rem_sh - trial;
        take   = (rem_sh >= trial);
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == SCW'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= r_rad << 2;
            r_rem  <= take ? diff[QW:0] : rem_sh[QW:0];
            r_root <= {r_root[QW-2:0], take};
        end
    end

    assign o_root      = r_root;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

[hw/rtl/mandelbrot_density_point_unit.sv]
// Channel   Direction  Signals                          Contents (lowest bit up)
// s_axis    in         tvalid tready tdata[63:0]        point_real[31:0], point_imag[31:0]
// m_axis    out        tvalid tready tdata[23:0] tuser  density[16:0] + zero fill; escaped
// cfg       in         i_cfg_valid o_cfg_ready data     iteration_limit[10:0]
//
// One point at a time, for a point that stays bounded: S_IDLE takes it, each z update
// runs S_SQ_R, S_SQ_I, S_CROSS and S_UPDATE (three products through the single 31x31
// multiplier plus the update; the last pass ends after S_CROSS), then the bit-serial
// square root runs in S_ROOT and S_FINISH loads the output register.
// An escaping point finishes as soon as the escape is seen.
// The result sits in an output register; the next point is taken while it waits.
// i_rst_n is synchronous, active low; the iteration limit resets to 64.
module mandelbrot_density_point_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [63:0]                 s_axis_tdata,   // point_real, point_imag
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [23:0]                 m_axis_tdata,   // density, zero fill
    output logic [0:0]                  m_axis_tuser,   // escaped
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [mdp_pkg::CW-1:0]      i_cfg_data      // iteration_limit
);

    localparam int F   = mdp_pkg::FRACTION_BITS;
    localparam int ZW  = mdp_pkg::ZW;
    localparam int PW  = mdp_pkg::PW;
    localparam int MW  = mdp_pkg::MW;
    localparam int NW  = mdp_pkg::NW;
    localparam int CW  = mdp_pkg::CW;
    localparam int CPW = mdp_pkg::CPW;
    localparam int RW  = mdp_pkg::RW;
    localparam int QW  = mdp_pkg::QW;
    localparam int DW  = mdp_pkg::DW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ_R,
        S_SQ_I,
        S_CROSS,
        S_UPDATE,
        S_ROOT,
        S_FINISH
    } t_state;

    t_state                    r_state,     n_state;
    logic [CW-1:0]             r_cfg_limit, n_cfg_limit;
    logic [CW-1:0]             r_limit,     n_limit;
    logic [CW-1:0]             r_count,     n_count;
    logic signed [CPW-1:0]     r_cr,        n_cr;
    logic signed [CPW-1:0]     r_ci,        n_ci;
    logic signed [ZW-1:0]      r_zr,        n_zr;
    logic signed [ZW-1:0]      r_zi,        n_zi;
    logic signed [PW-1:0]      r_sq_r,      n_sq_r;
    logic signed [PW-1:0]      r_sq_i,      n_sq_i;
    logic [DW-1:0]             r_fin_dens,  n_fin_dens;
    logic                      r_fin_esc,   n_fin_esc;
    logic                      r_out_valid, n_out_valid;
    logic [DW-1:0]             r_out_dens,  n_out_dens;
    logic                      r_out_esc,   n_out_esc;

    logic signed [ZW-1:0]      mul_a;
    logic signed [ZW-1:0]      mul_b;
    logic signed [PW-1:0]      prod;
    logic [MW-1:0]             mag;
    logic signed [PW:0]        sq_diff;
    logic signed [PW:0]        re_shift;
    logic signed [PW-1:0]      im_shift;
    logic signed [NW-1:0]      in_re;
    logic signed [NW-1:0]      in_im;
    logic signed [NW-1:0]      upd_re;
    logic signed [NW-1:0]      upd_im;
    logic                      sqrt_start;
    logic [RW-1:0]             radicand;
    logic [QW-1:0]             root;
    mdp_pkg::t_sqrt_stat       sqrt_stat;
    logic                      out_free;
    logic                      in_xact;

    mdp_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    mdp_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (radicand),
        .o_root     (root),
        .o_stat     (sqrt_stat)
    );

    // Multiplier operand select: zr^2, zi^2, zr*zi in turn
    always_comb begin
        case (r_state)
            S_SQ_R:  begin mul_a = r_zr; mul_b = r_zr; end
            S_SQ_I:  begin mul_a = r_zi; mul_b = r_zi; end
            S_CROSS: begin mul_a = r_zr; mul_b = r_zi; end
            default: begin mul_a = r_zr; mul_b = r_zr; end
        endcase
    end

    // Datapath arithmetic
    always_comb begin
        // |z|^2 while zi^2 is on the multiplier output
        mag      = {1'b0, r_sq_r} + {1'b0, prod};
        radicand = RW'(mag >> mdp_pkg::ROOT_SHIFT);
        // z update with floor rounding
        sq_diff  = {r_sq_r[PW-1], r_sq_r} - {r_sq_i[PW-1], r_sq_i};
        re_shift = sq_diff >>> F;
        im_shift = prod >>> (F - 1);
        upd_re   = re_shift[NW-1:0] + NW'(r_cr);
        upd_im   = im_shift[NW-1:0] + NW'(r_ci);
        // incoming point, sign extended
        in_re    = NW'($signed(s_axis_tdata[CPW-1:0]));
        in_im    = NW'($signed(s_axis_tdata[2*CPW-1:CPW]));
    end

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_xact       = s_axis_tvalid && s_axis_tready;
    assign sqrt_start    = (r_state == S_CROSS) && !(mag > mdp_pkg::FOUR_SQ)
                           && (r_count == r_limit);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_cfg_limit = r_cfg_limit;
        n_limit     = r_limit;
        n_count     = r_count;
        n_cr        = r_cr;
        n_ci        = r_ci;
        n_zr        = r_zr;
        n_zi        = r_zi;
        n_sq_r      = r_sq_r;
        n_sq_i      = r_sq_i;
        n_fin_dens  = r_fin_dens;
        n_fin_esc   = r_fin_esc;
        n_out_valid = r_out_valid;
        n_out_dens  = r_out_dens;
        n_out_esc   = r_out_esc;

        if (i_cfg_valid) begin
            n_cfg_limit = i_cfg_data;
        end
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_xact) begin
                    n_cr      = s_axis_tdata[CPW-1:0];
                    n_ci      = s_axis_tdata[2*CPW-1:CPW];
                    n_limit   = mdp_pkg::f_eff_limit(r_cfg_limit);
                    n_count   = {{(CW-1){1'b0}}, 1'b1};
                    n_zr      = in_re[ZW-1:0];
                    n_zi      = in_im[ZW-1:0];
                    // first update from zero gives z = c
                    if (mdp_pkg::f_far(in_re) || mdp_pkg::f_far(in_im)) begin
                        n_fin_dens = '0;
                        n_fin_esc  = 1'b1;
                        n_state    = S_FINISH;
                    end else begin
                        n_state = S_SQ_R;
                    end
                end
            end
            S_SQ_R: begin
                n_state = S_SQ_I;
            end
            S_SQ_I: begin
                n_sq_r  = prod;
                n_state = S_CROSS;
            end
            S_CROSS: begin
                n_sq_i = prod;
                if (mag > mdp_pkg::FOUR_SQ) begin
                    n_fin_dens = '0;
                    n_fin_esc  = 1'b1;
                    n_state    = S_FINISH;
                end else if (r_count == r_limit) begin
                    n_state = S_ROOT;
                end else begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                n_zr    = upd_re[ZW-1:0];
                n_zi    = upd_im[ZW-1:0];
                n_count = r_count + 1'b1;
                if (mdp_pkg::f_far(upd_re) || mdp_pkg::f_far(upd_im)) begin
                    n_fin_dens = '0;
                    n_fin_esc  = 1'b1;
                    n_state    = S_FINISH;
                end else begin
                    n_state = S_SQ_R;
                end
            end
            S_ROOT: begin
                if (sqrt_stat.done) begin
                    n_fin_esc  = 1'b0;
                    n_fin_dens = (root > mdp_pkg::ONE_DENSITY) ? '0
                                 : mdp_pkg::ONE_DENSITY - root;
                    n_state    = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_dens  = r_fin_dens;
                    n_out_esc   = r_fin_esc;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg_limit <= mdp_pkg::LIMIT_RESET;
            r_limit     <= mdp_pkg::LIMIT_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cfg_limit <= n_cfg_limit;
            r_limit     <= n_limit;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_cr       <= n_cr;
        r_ci       <= n_ci;
        r_zr       <= n_zr;
        r_zi       <= n_zi;
        r_sq_r     <= n_sq_r;
        r_sq_i     <= n_sq_i;
        r_fin_dens <= n_fin_dens;
        r_fin_esc  <= n_fin_esc;
        r_out_dens <= n_out_dens;
        r_out_esc  <= n_out_esc;
    end

    assign o_cfg_ready     = 1'b1;
    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = {{(24-DW){1'b0}}, r_out_dens};
    assign m_axis_tuser[0] = r_out_esc;

    // Square root runs only while the sequencer waits for it
    a_sqrt_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (sqrt_stat.busy || sqrt_stat.done) |-> (r_state == S_ROOT))
        else $error("square root active outside its state");

    // Iteration count stays within the latched limit
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQ_R || r_state == S_SQ_I || r_state == S_CROSS
         || r_state == S_UPDATE) |-> (r_count <= r_limit && r_count != '0))
        else $error("iteration count out of range");

    // An escaped result carries zero density
    a_escape_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_esc) |-> (r_out_dens == '0))
        else $error("escaped point with nonzero density");

    // Latched limit is always in the legal range while working
    a_limit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_limit != '0 && r_limit <= mdp_pkg::LIMIT_MAX))
        else $error("effective limit out of range");

    // A result leaves the sequencer only into a free output register
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && !out_free) |=> (r_state == S_FINISH))
        else $error("result dropped while output stalled");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb;

    localparam int                  FRACTION_BITS = mdp_pkg::FRACTION_BITS;
    localparam int                  CW            = mdp_pkg::CW;
    localparam int                  DW            = mdp_pkg::DW;
    localparam int                  ROOT_SHIFT    = mdp_pkg::ROOT_SHIFT;
    localparam logic [CW-1:0]       LIMIT_MAX     = mdp_pkg::LIMIT_MAX;
    localparam logic [CW-1:0]       LIMIT_RESET   = mdp_pkg::LIMIT_RESET;
    localparam logic [DW-1:0]       ONE_DENSITY   = mdp_pkg::ONE_DENSITY;

    localparam int CLK_HALF        = 10;
    localparam int CYCLE_LIMIT     = 2_000_000;
    localparam int HOLD_OFF_CYCLES = 1500;
    localparam int Q_ONE           = 1 << FRACTION_BITS;   // 1.0 in Q4.28
    localparam logic signed [127:0] ESCAPE_BOUND = 128'sd1 <<< (2 * FRACTION_BITS + 2);

    // One expected result, with the point kept for messages
    typedef struct {
        logic [31:0]   re;
        logic [31:0]   im;
        logic [DW-1:0] density;
        logic          escaped;
    } t_density_expect;

    logic          i_clk         = 1'b0;
    logic          i_rst_n       = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [63:0]   s_axis_tdata  = '0;   // point_real[31:0], point_imag[31:0]
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [23:0]   m_axis_tdata;         // density[16:0], zero fill[23:17]
    logic [0:0]    m_axis_tuser;         // escaped
    logic          i_cfg_valid   = 1'b0;
    logic          o_cfg_ready;
    logic [CW-1:0] i_cfg_data    = '0;   // iteration_limit

    t_density_expect pending_densities[$];
    logic [CW-1:0]   iter_limit     = LIMIT_RESET;
    int              send_idle_pct  = 0;
    int              recv_stall_pct = 0;
    logic            hold_request   = 1'b0;
    int              hold_left      = 0;
    int              cycle_count    = 0;
    int              error_count    = 0;
    int              points_sent    = 0;
    int              results_seen   = 0;
    int              escaped_seen   = 0;

    mandelbrot_density_point_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Bit-by-bit integer square root, floor
    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // Escape-time iteration on exact wide products, floor after each scale-down
    function automatic t_density_expect predict_density(input logic [31:0] re_bits,
                                                        input logic [31:0] im_bits,
                                                        input logic [CW-1:0] limit_bits);
        logic signed [31:0]  c_re;
        logic signed [31:0]  c_im;
        logic signed [127:0] z_re;
        logic signed [127:0] z_im;
        logic signed [127:0] sq_re;
        logic signed [127:0] sq_im;
        logic signed [127:0] prod_ri;
        logic signed [127:0] mag;
        logic [63:0]         root;
        int                  steps;
        t_density_expect     r;
        c_re      = re_bits;
        c_im      = im_bits;
        r.re      = re_bits;
        r.im      = im_bits;
        r.density = '0;
        r.escaped = 1'b1;
        if (limit_bits == '0) begin
            steps = 1;
        end else if (limit_bits > LIMIT_MAX) begin
            steps = int'(LIMIT_MAX);
        end else begin
            steps = int'(limit_bits);
        end
        z_re = '0;
        z_im = '0;
        mag  = '0;
        for (int k = 0; k < steps; k++) begin
            sq_re   = z_re * z_re;
            sq_im   = z_im * z_im;
            prod_ri = z_re * z_im;
            z_re    = ((sq_re - sq_im) >>> FRACTION_BITS) + c_re;
            z_im    = ((prod_ri <<< 1) >>> FRACTION_BITS) + c_im;
            mag     = z_re * z_re + z_im * z_im;
            if (mag > ESCAPE_BOUND) begin
                return r;
            end
        end
        // bounded: density = 1 - |z|/2 via sqrt of |z|^2 scaled to 2^30
        root = int_sqrt(64'(mag >>> ROOT_SHIFT));
        if (root > 64'(ONE_DENSITY)) begin
            root = 64'(ONE_DENSITY);
        end
        r.density = ONE_DENSITY - root[DW-1:0];
        r.escaped = 1'b0;
        return r;
    endfunction

    // Mostly points near or inside the set, some wild ones
    function automatic logic [63:0] random_point();
        int pick;
        int re;
        int im;
        pick = $urandom_range(99);
        if (pick < 40) begin
            re = -2 * Q_ONE + int'($urandom_range(0, 5 * Q_ONE / 2));
            im = -5 * Q_ONE / 4 + int'($urandom_range(0, 5 * Q_ONE / 2));
        end else if (pick < 60) begin
            // main cardioid interior, stays bounded
            re = -Q_ONE / 4 + int'($urandom_range(0, Q_ONE / 2));
            im = -Q_ONE / 4 + int'($urandom_range(0, Q_ONE / 2));
        end else if (pick < 75) begin
            // near the boundary, long escape times
            re = -(4 * Q_ONE / 5) + int'($urandom_range(0, Q_ONE / 10));
            im = Q_ONE / 20 + int'($urandom_range(0, 3 * Q_ONE / 20));
        end else if (pick < 80) begin
            // real axis, a few lsb off
            re = -2 * Q_ONE + int'($urandom_range(0, 9 * (Q_ONE / 4)));
            im = int'($urandom_range(0, 4)) - 2;
        end else if (pick < 92) begin
            re = int'($urandom);
            im = int'($urandom);
        end else begin
            case ($urandom_range(3))
                0: re = 32'h7FFF_FFFF;
                1: re = 32'h8000_0000;
                2: re = 0;
                default: re = -2 * Q_ONE;
            endcase
            case ($urandom_range(3))
                0: im = 32'h7FFF_FFFF;
                1: im = 32'h8000_0000;
                2: im = 0;
                default: im = -2 * Q_ONE;
            endcase
        end
        return {im[31:0], re[31:0]};
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // Send one point; valid stays up so back-to-back transactions need no gap
    task automatic send_point(input logic [31:0] re, input logic [31:0] im);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= {$urandom, $urandom};
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {im, re};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_densities.push_back(predict_density(re, im, iter_limit));
        points_sent++;
    endtask

    task automatic send_random_points(input int count);
        logic [63:0] pt;
        for (int n = 0; n < count; n++) begin
            pt = random_point();
            send_point(pt[31:0], pt[63:32]);
        end
    endtask

    // Stop offering and wait for every outstanding result
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_densities.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // Only called with the block idle
    task automatic write_limit(input logic [CW-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        iter_limit = value;
    endtask

    // Corners at the reset limit
    task automatic test_directed_points();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_point(32'd0, 32'd0);                  // origin, full density
        send_point(-2 * Q_ONE, 0);                 // |z|^2 sits at exactly 4
        send_point(2 * Q_ONE, 0);                  // escapes on the second update
        send_point(Q_ONE / 4, 0);                  // cusp, slow convergence
        send_point(0, Q_ONE);                      // periodic orbit through -1+i
        send_point(0, -Q_ONE);
        send_point(-Q_ONE, 0);                     // 0, -1 cycle
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);  // far outside
        send_point(32'h8000_0000, 32'h8000_0000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000);
        send_point(32'h8000_0000, 32'h7FFF_FFFF);
        send_point(-2 * Q_ONE, 1);                 // just off the tip
        send_point(-3 * Q_ONE / 4, Q_ONE / 10);
        send_point(Q_ONE / 2, 0);
        send_point(32'h5555_5555, 32'hAAAA_AAAA);
        send_point(32'hAAAA_AAAA, 32'h5555_5555);
        wait_results_drained();
    endtask

    // Limit of one, zero (as one), above range (saturates) and the maximum
    task automatic test_limit_extremes();
        write_limit(11'd1);
        send_random_points(20);
        wait_results_drained();
        write_limit(11'd0);
        send_random_points(20);
        wait_results_drained();
        write_limit(11'h7FF);
        send_point(32'd0, 32'd0);
        send_point(-2 * Q_ONE, 0);
        send_point(-Q_ONE, 0);
        send_random_points(3);
        wait_results_drained();
        write_limit(LIMIT_MAX);
        send_point(Q_ONE / 4, 0);
        send_point(0, Q_ONE);
        send_random_points(2);
        wait_results_drained();
    endtask

    // Long output stall while points keep coming: input must back up
    task automatic test_output_hold_off();
        write_limit(11'd16);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request <= 1'b1;
        @(posedge i_clk);
        hold_request <= 1'b0;
        send_random_points(10);
        wait_results_drained();
    endtask

    // Random traffic under the four idle/stall mixes
    task automatic test_random_traffic();
        int send_pcts[4] = '{0, 52, 0, 28};
        int recv_pcts[4] = '{0, 0, 52, 28};
        for (int ph = 0; ph < 4; ph++) begin
            write_limit(CW'($urandom_range(2, 160)));
            send_idle_pct  = send_pcts[ph];
            recv_stall_pct = recv_pcts[ph];
            send_random_points(65);
            if (ph == 1) begin
                // sender pauses until everything is back
                wait_results_drained();
            end
            send_random_points(65);
            wait_results_drained();
        end
    endtask

    // Receiver: random stalls, or a counted hold-off when requested
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result checker: oldest expectation against each output transaction
    always @(posedge i_clk) begin
        t_density_expect want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_densities.size() == 0) begin
                report_mismatch($sformatf("unexpected result density %0d escaped %0b",
                                          m_axis_tdata[DW-1:0], m_axis_tuser[0]));
            end else begin
                want = pending_densities.pop_front();
                results_seen++;
                if (m_axis_tuser[0] === 1'b1) begin
                    escaped_seen++;
                end
                if (m_axis_tdata[DW-1:0] !== want.density) begin
                    report_mismatch($sformatf("c=(%h,%h) density got %0d want %0d",
                                              want.re, want.im, m_axis_tdata[DW-1:0],
                                              want.density));
                end
                if (m_axis_tuser[0] !== want.escaped) begin
                    report_mismatch($sformatf("c=(%h,%h) escaped got %b want %b",
                                              want.re, want.im, m_axis_tuser[0],
                                              want.escaped));
                end
                if (m_axis_tdata[23:DW] !== '0) begin
                    report_mismatch($sformatf("c=(%h,%h) fill bits nonzero: %h",
                                              want.re, want.im, m_axis_tdata[23:DW]));
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_densities.size());
            $display("mandelbrot_density_point_unit regression: fail");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_points();
        test_limit_extremes();
        test_output_hold_off();
        test_random_traffic();

        wait_results_drained();
        repeat (200) @(posedge i_clk);
        for (int n = 0; n < pending_densities.size(); n++) begin
            report_mismatch($sformatf("no result for c=(%h,%h)",
                                      pending_densities[n].re, pending_densities[n].im));
        end
        $display("covered %0d points (%0d escaped, %0d bounded), %0d mismatches",
                 points_sent, escaped_seen, results_seen - escaped_seen, error_count);
        $display("limits 0/1/1024/2047 and random, long output hold-off, four idle mixes");
        if (error_count == 0) begin
            $display("mandelbrot_density_point_unit regression: pass");
        end else begin
            $display("mandelbrot_density_point_unit regression: fail");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/mdp_pkg.sv
hw/rtl/mdp_mul.sv
hw/rtl/mdp_isqrt.sv
hw/rtl/mandelbrot_density_point_unit.sv
tb/sv/tb.sv
